@@ rtl/clq_pkg.sv @@
// Package for the CAN lowest-identifier arbitration queue.
// Holds the beat types, status codes, controller states and limits.
// Depends on nothing; the cell and the top level import it.
`default_nettype none

package clq_pkg;

	localparam int DEFAULT_QUEUE_DEPTH = 8;

	localparam logic [11:0] ID_LIMIT  = 12'd2047;
	localparam logic [3:0]  DLC_LIMIT = 4'd8;

	typedef enum logic [0:0] {
		OP_QUEUE     = 1'b0,
		OP_ARBITRATE = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_QUEUED  = 3'd0,
		ST_FULL    = 3'd1,
		ST_INVALID = 3'd2,
		ST_SENT    = 3'd3,
		ST_EMPTY   = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CTL_IDLE,
		CTL_SCAN,
		CTL_DONE
	} ctl_state_t;

	// One request beat.
	typedef struct packed {
		op_t         operation;
		logic [11:0] frame_id;
		logic [3:0]  frame_dlc;
		logic [63:0] frame_payload;
		logic [7:0]  source_tag;
	} req_t;

	// One result beat.
	typedef struct packed {
		status_t     status;
		logic [10:0] winner_id;
		logic [3:0]  winner_dlc;
		logic [63:0] winner_payload;
		logic [7:0]  winner_source;
		logic [3:0]  queue_level;
		logic [31:0] sent_count;
		logic [31:0] invalid_count;
	} rsp_t;

	// A frame as it sits in a queue cell.
	typedef struct packed {
		logic [10:0] id;
		logic [3:0]  dlc;
		logic [63:0] payload;
		logic [7:0]  src;
	} entry_t;

	// The running best candidate handed from cell to cell.
	typedef struct packed {
		logic   valid;
		entry_t entry;
	} token_t;

	// Write and shift controls that the top level gives one cell.
	typedef struct packed {
		logic occupied;
		logic load;
		logic shift;
	} cell_ctl_t;

endpackage

`default_nettype wire

@@ rtl/clq_cell.sv @@
// One slot of the arbitration queue: holds a frame and one stage of the
// minimum-identifier search that runs along the row of cells.
// Depends on clq_pkg.
`default_nettype none

module clq_cell #(
	parameter int IDX_W    = 3,
	parameter int CELL_IDX = 0
) (
	input  wire                  clk,
	input  clq_pkg::cell_ctl_t   ctl,
	input  clq_pkg::entry_t      load_entry,
	input  clq_pkg::entry_t      right_entry,
	output clq_pkg::entry_t      entry,
	input  clq_pkg::token_t      tok_in,
	input  wire [IDX_W-1:0]      tok_idx_in,
	output clq_pkg::token_t      tok_out,
	output logic [IDX_W-1:0]     tok_idx_out
);
	import clq_pkg::*;

	entry_t entry_q;
	token_t tok_q;
	logic [IDX_W-1:0] tok_idx_q;
	logic own_wins;

	// Strict less-than keeps the earlier frame on a tie.
	assign own_wins = ctl.occupied && (!tok_in.valid || entry_q.id < tok_in.entry.id);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			entry_q <= load_entry;
		end else if (ctl.shift) begin
			entry_q <= right_entry;
		end
		if (own_wins) begin
			tok_q     <= '{valid: 1'b1, entry: entry_q};
			tok_idx_q <= IDX_W'(CELL_IDX);
		end else begin
			tok_q     <= tok_in;
			tok_idx_q <= tok_idx_in;
		end
	end

	assign entry       = entry_q;
	assign tok_out     = tok_q;
	assign tok_idx_out = tok_idx_q;

endmodule

`default_nettype wire

@@ rtl/can_lowest_id_arbitration_queue_unit.sv @@
// Top level of the CAN lowest-identifier arbitration queue.
// Builds the row of clq_cell slots and the controller; depends on clq_pkg.
//
//   channel | direction | handshake            | beat type
//   req     | in        | req_valid, req_ready | clq_pkg::req_t
//   rsp     | out       | rsp_valid, rsp_ready | clq_pkg::rsp_t
//
// A queue request, or an arbitration on an empty queue, goes from the idle state to
// the done state, where its result beat is registered, and then back to idle. Any other
// arbitration passes through the scan state first, while the lowest-identifier search
// walks the cells one stage per cell. A new request is taken only in the idle state.
// Reset (arst_n low) empties the queue and clears both counters. While a result beat
// waits, one more request is taken and held until the output register is free.
`default_nettype none

module can_lowest_id_arbitration_queue_unit #(
	parameter int QUEUE_DEPTH = clq_pkg::DEFAULT_QUEUE_DEPTH
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            req_valid,
	output logic           req_ready,
	input  clq_pkg::req_t  req,
	output logic           rsp_valid,
	input  wire            rsp_ready,
	output clq_pkg::rsp_t  rsp
);
	import clq_pkg::*;

	localparam int IDX_W  = $clog2(QUEUE_DEPTH);
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

	// Controller state.
	ctl_state_t state_q, state_d;
	req_t item_q;
	logic [IDX_W-1:0] scan_cnt_q;
	logic [FILL_W-1:0] fill_q;
	logic [31:0] sent_q;
	logic [31:0] inv_q;
	rsp_t rsp_q;
	logic rsp_valid_q;

	// Row of cells.
	cell_ctl_t ctl [QUEUE_DEPTH];
	entry_t entries [QUEUE_DEPTH];
	token_t toks [QUEUE_DEPTH+1];
	logic [IDX_W-1:0] tok_idx [QUEUE_DEPTH+1];
	entry_t new_entry;

	// Decisions taken when an item finishes.
	logic req_fire;
	logic finish;
	logic do_push;
	logic do_pop;
	logic do_invalid;
	status_t res_status;
	rsp_t res;

	assign req_fire = req_valid && req_ready;
	assign finish   = (state_q == CTL_DONE) && (!rsp_valid_q || rsp_ready);

	assign new_entry = '{
		id:      item_q.frame_id[10:0],
		dlc:     item_q.frame_dlc,
		payload: item_q.frame_payload,
		src:     item_q.source_tag
	};

	// The head of the row sees no candidate yet.
	assign toks[0]    = '0;
	assign tok_idx[0] = '0;

	for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
		assign ctl[k].occupied = fill_q > FILL_W'(k);
		assign ctl[k].load     = do_push && (fill_q == FILL_W'(k));
		assign ctl[k].shift    = do_pop && (IDX_W'(k) >= tok_idx[QUEUE_DEPTH]);

		clq_cell #(
			.IDX_W    (IDX_W),
			.CELL_IDX (k)
		) u_cell (
			.clk         (clk),
			.ctl         (ctl[k]),
			.load_entry  (new_entry),
			.right_entry (entries[(k == QUEUE_DEPTH-1) ? k : k+1]),
			.entry       (entries[k]),
			.tok_in      (toks[k]),
			.tok_idx_in  (tok_idx[k]),
			.tok_out     (toks[k+1]),
			.tok_idx_out (tok_idx[k+1])
		);
	end

	// Outcome of the item held by the controller, valid in the done state.
	always_comb begin
		do_push    = 1'b0;
		do_pop     = 1'b0;
		do_invalid = 1'b0;
		res_status = ST_QUEUED;
		if (item_q.operation == OP_QUEUE) begin
			if (fill_q >= FILL_W'(QUEUE_DEPTH)) begin
				res_status = ST_FULL;
			end else if (item_q.frame_id > ID_LIMIT || item_q.frame_dlc > DLC_LIMIT) begin
				res_status = ST_INVALID;
				do_invalid = finish;
			end else begin
				res_status = ST_QUEUED;
				do_push    = finish;
			end
		end else begin
			if (fill_q == '0) begin
				res_status = ST_EMPTY;
			end else begin
				res_status = ST_SENT;
				do_pop     = finish;
			end
		end
	end

	// Result beat as it leaves with the updated queue level and counters.
	always_comb begin
		res = '0;
		res.status = res_status;
		if (res_status == ST_SENT) begin
			res.winner_id      = toks[QUEUE_DEPTH].entry.id;
			res.winner_dlc     = toks[QUEUE_DEPTH].entry.dlc;
			res.winner_payload = toks[QUEUE_DEPTH].entry.payload;
			res.winner_source  = toks[QUEUE_DEPTH].entry.src;
		end
		res.queue_level   = 4'(fill_q + FILL_W'(do_push) - FILL_W'(do_pop));
		res.sent_count    = sent_q + 32'(do_pop);
		res.invalid_count = inv_q + 32'(do_invalid);
	end

	// Next state. The search has to pass the register of every cell to reach the end
	// of the row, so an arbitration on a non-empty queue waits in the scan state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			CTL_IDLE: begin
				if (req_fire) begin
					if (req.operation == OP_ARBITRATE && fill_q != '0) begin
						state_d = CTL_SCAN;
					end else begin
						state_d = CTL_DONE;
					end
				end
			end
			CTL_SCAN: begin
				if (scan_cnt_q == IDX_W'(QUEUE_DEPTH - 1)) begin
					state_d = CTL_DONE;
				end
			end
			CTL_DONE: begin
				if (finish) begin
					state_d = CTL_IDLE;
				end
			end
			default: state_d = CTL_IDLE;
		endcase
	end

	// Outputs of the controller.
	always_comb begin
		req_ready = (state_q == CTL_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CTL_IDLE;
			scan_cnt_q  <= '0;
			fill_q      <= '0;
			sent_q      <= '0;
			inv_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == CTL_SCAN) begin
				scan_cnt_q <= scan_cnt_q + 1'b1;
			end else begin
				scan_cnt_q <= '0;
			end
			if (do_push) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop) begin
				fill_q <= fill_q - 1'b1;
			end
			if (do_pop) begin
				sent_q <= sent_q + 1'b1;
			end
			if (do_invalid) begin
				inv_q <= inv_q + 1'b1;
			end
			if (finish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (req_fire) begin
			item_q <= req;
		end
		if (finish) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(QUEUE_DEPTH))
		else $error("queue fill exceeds depth");

	a_pop_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(finish && res_status == ST_SENT) |=> fill_q == $past(fill_q) - 1'b1)
		else $error("sent frame did not shrink the queue");

	a_push_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(finish && res_status == ST_QUEUED) |=> fill_q == $past(fill_q) + 1'b1)
		else $error("queued frame did not grow the queue");

	a_sent_winner: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == CTL_DONE && res_status == ST_SENT) |-> toks[QUEUE_DEPTH].valid)
		else $error("arbitration finished without a candidate");
`endif

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for can_lowest_id_arbitration_queue_unit.
// Predicts every result beat from its own copy of the transmit queue and counters.
// Depends on clq_pkg and the unit itself; reads nothing else.

module tb_top;
	import clq_pkg::*;

	localparam int QDEPTH = DEFAULT_QUEUE_DEPTH;
	// No handshake on either side for this many cycles means the unit is stuck.
	localparam int STALL_LIMIT = 2000;
	// Length of the deliberate receiver hold-off in the backpressure test.
	localparam int HOLD_CYCLES = 120;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	can_lowest_id_arbitration_queue_unit #(
		.QUEUE_DEPTH(QDEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Shadow of the unit's state. Frames sit in arrival order, so the position
	// in the queue breaks ties between equal identifiers.
	entry_t pending_frames[$];
	logic [31:0] sent_frames = '0;
	logic [31:0] refused_frames = '0;

	// Result beats still owed by the unit, oldest first.
	rsp_t owed_results[$];
	int unsigned mismatches = 0;

	// Sender pacing: bursts of back-to-back beats separated by idle gaps.
	bit tx_bursty = 1'b0;
	int unsigned burst_left = 1;

	// Receiver pacing. rx_throttle selects stalls against a steady ready;
	// each increment of hold_asks requests one long hold-off.
	bit rx_throttle = 1'b0;
	int unsigned hold_asks = 0;
	int unsigned hold_served = 0;
	int unsigned hold_left = 0;
	int unsigned rx_run = 0;
	bit rx_stalling = 1'b0;
	int unsigned idle_cycles = 0;

	// Applies one accepted request beat to the shadow state and returns the
	// result beat that the unit has to produce for it.
	function automatic rsp_t predict_queue_result(input req_t beat);
		rsp_t res;
		entry_t frame;
		int pick;
		res = '0;
		if (beat.operation == OP_QUEUE) begin
			if (pending_frames.size() >= QDEPTH) begin
				// A full queue refuses before the frame is even looked at.
				res.status = ST_FULL;
			end else if (beat.frame_id > ID_LIMIT || beat.frame_dlc > DLC_LIMIT) begin
				refused_frames = refused_frames + 1;
				res.status = ST_INVALID;
			end else begin
				frame.id = beat.frame_id[10:0];
				frame.dlc = beat.frame_dlc;
				frame.payload = beat.frame_payload;
				frame.src = beat.source_tag;
				pending_frames.push_back(frame);
				res.status = ST_QUEUED;
			end
		end else if (pending_frames.size() == 0) begin
			res.status = ST_EMPTY;
		end else begin
			// Strict less-than keeps the earliest frame on a tie.
			pick = 0;
			for (int k = 1; k < pending_frames.size(); k++) begin
				if (pending_frames[k].id < pending_frames[pick].id)
					pick = k;
			end
			res.winner_id = pending_frames[pick].id;
			res.winner_dlc = pending_frames[pick].dlc;
			res.winner_payload = pending_frames[pick].payload;
			res.winner_source = pending_frames[pick].src;
			pending_frames.delete(pick);
			sent_frames = sent_frames + 1;
			res.status = ST_SENT;
		end
		res.queue_level = 4'(pending_frames.size());
		res.sent_count = sent_frames;
		res.invalid_count = refused_frames;
		return res;
	endfunction

	function automatic req_t make_beat(input op_t op, input logic [11:0] id,
			input logic [3:0] dlc, input logic [63:0] payload, input logic [7:0] src);
		req_t beat;
		beat.operation = op;
		beat.frame_id = id;
		beat.frame_dlc = dlc;
		beat.frame_payload = payload;
		beat.source_tag = src;
		return beat;
	endfunction

	// The unit ignores the frame fields of an arbitrate beat, so they carry noise.
	function automatic req_t arbitrate_beat();
		return make_beat(OP_ARBITRATE, 12'($urandom), 4'($urandom),
			{$urandom, $urandom}, 8'($urandom));
	endfunction

	// Mostly well-formed frames, with narrow identifier ranges to force ties,
	// and a small share of refused or fully random frames.
	function automatic req_t random_beat(input int unsigned queue_pct);
		req_t beat;
		int unsigned roll;
		if ($urandom_range(0, 99) >= queue_pct)
			return arbitrate_beat();
		beat = make_beat(OP_QUEUE, 12'($urandom_range(0, 2047)), 4'($urandom_range(0, 8)),
			{$urandom, $urandom}, 8'($urandom));
		roll = $urandom_range(0, 99);
		if (roll < 4) begin
			beat.frame_id = 12'($urandom_range(2048, 4095));
			beat.frame_dlc = 4'($urandom);
		end else if (roll < 8) begin
			beat.frame_dlc = 4'($urandom_range(9, 15));
		end else if (roll < 11) begin
			beat.frame_id = 12'($urandom);
			beat.frame_dlc = 4'($urandom);
		end else if (roll < 45) begin
			beat.frame_id = 12'($urandom_range(0, 15));
		end
		return beat;
	endfunction

	// Offers one request beat, waits for the handshake and records the result
	// that it owes. The caller is always at a rising edge when this starts, and
	// valid is only lowered here when an idle gap follows.
	task automatic send_beat(input req_t beat);
		req <= beat;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		owed_results.push_back(predict_queue_result(beat));
		if (tx_bursty) begin
			burst_left--;
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 12);
				req_valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	endtask

	task automatic wait_all_results();
		req_valid <= 1'b0;
		wait (owed_results.size() == 0);
		@(posedge clk);
	endtask

	// Extremes of every field, refused frames of each kind, a full queue with
	// both a good and a bad frame, ties on one identifier, and an empty queue.
	task automatic test_directed_cases();
		tx_bursty = 1'b0;
		rx_throttle <= 1'b0;
		send_beat(arbitrate_beat());
		send_beat(make_beat(OP_QUEUE, 12'd0, 4'd0, 64'd0, 8'd0));
		send_beat(make_beat(OP_QUEUE, 12'd2047, 4'd8, '1, 8'hFF));
		send_beat(make_beat(OP_QUEUE, 12'd2048, 4'd0, {$urandom, $urandom}, 8'h11));
		send_beat(make_beat(OP_QUEUE, 12'hFFF, 4'hF, '1, 8'h22));
		send_beat(make_beat(OP_QUEUE, 12'd5, 4'd9, {$urandom, $urandom}, 8'h33));
		for (int s = 1; s <= 3; s++)
			send_beat(make_beat(OP_QUEUE, 12'd5, 4'(s), {$urandom, $urandom}, 8'(s)));
		send_beat(make_beat(OP_QUEUE, 12'd100, 4'd7, {$urandom, $urandom}, 8'h44));
		send_beat(make_beat(OP_QUEUE, 12'd1, 4'd2, 64'h5555_AAAA_5555_AAAA, 8'h55));
		send_beat(make_beat(OP_QUEUE, 12'd2047, 4'd3, 64'hAAAA_5555_AAAA_5555, 8'hAA));
		send_beat(make_beat(OP_QUEUE, 12'd9, 4'd4, {$urandom, $urandom}, 8'h66));
		send_beat(make_beat(OP_QUEUE, 12'hFFF, 4'hF, {$urandom, $urandom}, 8'h77));
		repeat (QDEPTH) send_beat(arbitrate_beat());
		send_beat(arbitrate_beat());
		wait_all_results();
	endtask

	// Switches at random between filling, balanced and draining phases so that the queue
	// swings between empty and full, while both sides change their pacing now and then.
	task automatic test_random_traffic(input int unsigned count);
		int unsigned queue_pct;
		queue_pct = 50;
		for (int unsigned n = 0; n < count; n++) begin
			if (n % 40 == 0) begin
				case ($urandom_range(0, 2))
					0: queue_pct = 80;
					1: queue_pct = 50;
					default: queue_pct = 25;
				endcase
			end
			if (n % 90 == 0) begin
				tx_bursty = $urandom_range(0, 3) != 0;
				rx_throttle <= $urandom_range(0, 3) != 0;
			end
			send_beat(random_beat(queue_pct));
		end
		wait_all_results();
	endtask

	// The receiver holds off for a long stretch while request beats keep
	// coming back to back, so the unit backs up and drops req_ready.
	task automatic test_output_backpressure(input int unsigned count);
		tx_bursty = 1'b0;
		hold_asks <= hold_asks + 1;
		for (int unsigned n = 0; n < count; n++)
			send_beat(random_beat(60));
		wait_all_results();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_cases();
		test_random_traffic(540);
		test_output_backpressure(40);
		// An arbitration is the slowest item; give the unit time to show any
		// stray beat before the verdict.
		repeat (2 * QDEPTH + 4) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Receiver. Its counters live here only; the test just asks for a hold-off.
	always @(posedge clk) begin
		if (hold_asks != hold_served) begin
			hold_served = hold_asks;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			rsp_ready <= 1'b0;
		end else if (!rx_throttle) begin
			rsp_ready <= 1'b1;
		end else begin
			if (rx_run == 0) begin
				rx_stalling = !rx_stalling;
				rx_run = rx_stalling ? $urandom_range(1, 6) : $urandom_range(1, 10);
			end
			rx_run--;
			rsp_ready <= !rx_stalling;
		end
	end

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Every accepted result beat is held against the oldest owed result.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (owed_results.size() == 0) begin
				$display("%0t ns: result beat with none owed, status %0d", $time, rsp.status);
				mismatches++;
			end else begin
				want = owed_results.pop_front();
				check_field("status", 64'(want.status), 64'(rsp.status));
				check_field("winner_id", 64'(want.winner_id), 64'(rsp.winner_id));
				check_field("winner_dlc", 64'(want.winner_dlc), 64'(rsp.winner_dlc));
				check_field("winner_payload", want.winner_payload, rsp.winner_payload);
				check_field("winner_source", 64'(want.winner_source), 64'(rsp.winner_source));
				check_field("queue_level", 64'(want.queue_level), 64'(rsp.queue_level));
				check_field("sent_count", 64'(want.sent_count), 64'(rsp.sent_count));
				check_field("invalid_count", 64'(want.invalid_count), 64'(rsp.invalid_count));
			end
		end
	end

	// Watchdog: any handshake on either side restarts the count.
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == STALL_LIMIT) begin
			$display("%0t ns: no handshake for %0d cycles", $time, STALL_LIMIT);
			$display("FAILURE");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule

@@ sim.f @@
rtl/clq_pkg.sv
rtl/clq_cell.sv
rtl/can_lowest_id_arbitration_queue_unit.sv
tb/tb_top.sv
